>>> sv/res_pkg.sv
// Shared types and constants for the rumble effect scheduler.
package res_pkg;

  localparam int EFFECT_SLOTS_DEF = 8;
  localparam int LEVEL_MAX        = 127;
  localparam int MAG_SHIFT        = 9;

  localparam logic [2:0] OP_UPLOAD = 3'd0;
  localparam logic [2:0] OP_PLAY   = 3'd1;
  localparam logic [2:0] OP_ERASE  = 3'd2;
  localparam logic [2:0] OP_FLUSH  = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_DENIED  = 3'd2;
  localparam logic [2:0] ST_BUSY    = 3'd3;
  localparam logic [2:0] ST_NOSPACE = 3'd4;
  localparam logic [2:0] ST_UNSUP   = 3'd5;

  // flag bits: started, playing, used
  localparam int F_STARTED = 0;
  localparam int F_PLAYING = 1;
  localparam int F_USED    = 2;

  typedef struct packed {
    logic [15:0] owner;
    logic [6:0]  left;
    logic [6:0]  right;
    logic [15:0] delay;
    logic [15:0] length;
    logic [15:0] repeats;
    logic [15:0] countdown;
  } slot_rec_t;

endpackage

>>> sv/res_slot_mem.sv
// Single-port slot record memory, registered read.
module res_slot_mem import res_pkg::*; #(
  parameter int DEPTH = EFFECT_SLOTS_DEF,
  parameter int AW    = 3
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   addr,
  input  slot_rec_t       wdata,
  output slot_rec_t       rdata
);

  slot_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> sv/rumble_effect_scheduler.sv
// Top level of the rumble effect scheduler.
//
// One request or millisecond tick is taken when start is high and busy is low.
// Results come out on out_valid and cannot be held off: zero or
// more rumble packets (out_kind=1) followed by exactly one status item
// (out_kind=0, out_last=1). An invalid opcode, a bad slot id or a failed
// allocation goes straight to the status item; upload, play and erase read
// and write back one record; flush and tick walk every slot through the
// single record memory port, one read and one write-back per slot. Packets
// carry running sums of the playing slots' levels, kept in registers and
// updated at each write-back, saturated to 127 on output.
// Slot flags live in flops and clear at reset; the record memory needs no
// clearing, since no record field is read before the request that writes it.
module rumble_effect_scheduler import res_pkg::*; #(
  parameter int EFFECT_SLOTS = EFFECT_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_opcode,
  input  logic signed [3:0] in_effect_id,
  input  logic [15:0]       in_requester,
  input  logic [15:0]       in_strong_magnitude,
  input  logic [15:0]       in_weak_magnitude,
  input  logic [15:0]       in_delay_ms,
  input  logic [15:0]       in_length_ms,
  input  logic [15:0]       in_play_count,
  output logic              out_valid,
  output logic              out_kind,
  output logic [2:0]        out_status,
  output logic [2:0]        out_slot_id,
  output logic [6:0]        out_left_level,
  output logic [6:0]        out_right_level,
  output logic              out_last
);

  localparam int SW   = (EFFECT_SLOTS > 1) ? $clog2(EFFECT_SLOTS) : 1;
  localparam int SUMW = $clog2(EFFECT_SLOTS * LEVEL_MAX + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EX   = 2'd2;
  localparam logic [1:0] S_ST   = 2'd3;

  logic [1:0]        state_r;
  logic [2:0]        op_r;
  logic [15:0]       who_r, strong_r, weak_r, dly_r, len_r, cnt_r;
  logic              alloc_r;
  logic [SW-1:0]     slot_r;
  logic [2:0]        sid_r, st_r;
  logic [2:0]        flags_r [EFFECT_SLOTS];
  logic [SUMW-1:0]   suml_r, sumr_r;

  logic              out_valid_r, out_kind_r, out_last_r;
  logic [2:0]        out_status_r, out_slot_r;
  logic [6:0]        out_left_r, out_right_r;

  slot_rec_t         rec, wr;
  logic              mem_we;

  // free slot search for allocation
  logic              free_found;
  logic [SW-1:0]     free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = EFFECT_SLOTS - 1; i >= 0; i--) begin
      if (!flags_r[i][F_USED]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  logic id_in_range;
  assign id_in_range = !in_effect_id[3] && (32'(in_effect_id[2:0]) < EFFECT_SLOTS);

  res_slot_mem #(.DEPTH(EFFECT_SLOTS), .AW(SW)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .addr (slot_r),
    .wdata(wr),
    .rdata(rec)
  );

  // ---- per-slot read-modify-write in S_EX ----
  logic [2:0]      f, f_new;
  logic            pkt, access_ok, armed;
  logic [2:0]      st_n;
  logic [SUMW-1:0] suml_nxt, sumr_nxt;

  always_comb begin
    f         = flags_r[slot_r];
    f_new     = f;
    wr        = rec;
    pkt       = 1'b0;
    st_n      = st_r;
    access_ok = f[F_USED] && (who_r == 16'd0 || rec.owner == who_r);
    armed     = f[F_STARTED] || f[F_PLAYING];
    case (op_r)
      OP_UPLOAD: begin
        if (alloc_r) begin
          wr.owner = who_r;
          f_new    = 3'b100;
        end
        if (!alloc_r && !access_ok) begin
          st_n = ST_DENIED;
        end else if (!alloc_r && armed) begin
          if (dly_r != rec.delay || len_r != rec.length) begin
            st_n = ST_UNSUP;
          end else begin
            wr.left  = weak_r[15:MAG_SHIFT];
            wr.right = strong_r[15:MAG_SHIFT];
            pkt      = 1'b1;
          end
        end else begin
          wr.left   = weak_r[15:MAG_SHIFT];
          wr.right  = strong_r[15:MAG_SHIFT];
          wr.delay  = dly_r;
          wr.length = len_r;
        end
      end
      OP_PLAY: begin
        if (!access_ok) begin
          st_n = ST_DENIED;
        end else if (cnt_r != 16'd0) begin
          if (armed) begin
            st_n = ST_BUSY;
          end else begin
            wr.repeats = cnt_r;
            if (rec.delay != 16'd0) begin
              f_new[F_STARTED] = 1'b1;
              wr.countdown     = rec.delay;
            end else begin
              f_new[F_PLAYING] = 1'b1;
              wr.countdown     = rec.length;
              pkt              = 1'b1;
            end
          end
        end else if (f[F_STARTED]) begin
          f_new[F_STARTED] = 1'b0;
        end else if (f[F_PLAYING]) begin
          f_new[F_PLAYING] = 1'b0;
          pkt              = 1'b1;
        end
      end
      OP_ERASE: begin
        if (!access_ok) begin
          st_n = ST_DENIED;
        end else begin
          f_new = 3'b000;
          pkt   = 1'b1;
        end
      end
      OP_FLUSH: begin
        if (f[F_USED] && rec.owner == who_r) begin
          f_new = 3'b000;
          pkt   = 1'b1;
        end
      end
      OP_TICK: begin
        if (armed) begin
          if (rec.countdown > 16'd1) begin
            wr.countdown = rec.countdown - 16'd1;
          end else if (f[F_STARTED]) begin
            f_new[F_STARTED] = 1'b0;
            f_new[F_PLAYING] = 1'b1;
            wr.countdown     = rec.length;
            pkt              = 1'b1;
          end else begin
            f_new[F_PLAYING] = 1'b0;
            wr.repeats       = rec.repeats - 16'd1;
            pkt              = 1'b1;
            if (rec.repeats != 16'd1) begin
              f_new[F_STARTED] = 1'b1;
              wr.countdown     = rec.delay;
            end
          end
        end
      end
      default: ;
    endcase
    // running sums: drop old contribution, add new one
    suml_nxt = suml_r - (f[F_PLAYING] ? SUMW'(rec.left) : '0)
                      + (f_new[F_PLAYING] ? SUMW'(wr.left) : '0);
    sumr_nxt = sumr_r - (f[F_PLAYING] ? SUMW'(rec.right) : '0)
                      + (f_new[F_PLAYING] ? SUMW'(wr.right) : '0);
  end

  assign mem_we = (state_r == S_EX);

  logic slot_last;
  assign slot_last = (slot_r == SW'(EFFECT_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      suml_r      <= '0;
      sumr_r      <= '0;
      for (int i = 0; i < EFFECT_SLOTS; i++) begin
        flags_r[i] <= 3'b000;
      end
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r     <= in_opcode;
            who_r    <= in_requester;
            strong_r <= in_strong_magnitude;
            weak_r   <= in_weak_magnitude;
            dly_r    <= in_delay_ms;
            len_r    <= in_length_ms;
            cnt_r    <= in_play_count;
            alloc_r  <= 1'b0;
            st_r     <= ST_OK;
            sid_r    <= 3'd0;
            slot_r   <= '0;
            case (in_opcode)
              OP_FLUSH, OP_TICK: begin
                state_r <= S_RD;
              end
              OP_UPLOAD, OP_PLAY, OP_ERASE: begin
                sid_r <= in_effect_id[2:0];
                if (in_opcode == OP_UPLOAD && in_effect_id == -4'sd1) begin
                  if (free_found) begin
                    alloc_r <= 1'b1;
                    slot_r  <= free_idx;
                    sid_r   <= 3'(free_idx);
                    state_r <= S_RD;
                  end else begin
                    st_r    <= ST_NOSPACE;
                    sid_r   <= 3'd0;
                    state_r <= S_ST;
                  end
                end else if (id_in_range) begin
                  slot_r  <= SW'(in_effect_id[2:0]);
                  state_r <= S_RD;
                end else begin
                  st_r    <= ST_DENIED;
                  state_r <= S_ST;
                end
              end
              default: begin
                st_r    <= ST_INVALID;
                state_r <= S_ST;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_EX;
        end
        S_EX: begin
          flags_r[slot_r] <= f_new;
          suml_r          <= suml_nxt;
          sumr_r          <= sumr_nxt;
          st_r            <= st_n;
          if (pkt) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= 1'b1;
            out_status_r <= ST_OK;
            out_slot_r   <= 3'(slot_r);
            out_left_r   <= (suml_nxt > SUMW'(LEVEL_MAX)) ? 7'(LEVEL_MAX) : suml_nxt[6:0];
            out_right_r  <= (sumr_nxt > SUMW'(LEVEL_MAX)) ? 7'(LEVEL_MAX) : sumr_nxt[6:0];
            out_last_r   <= 1'b0;
          end
          if ((op_r == OP_FLUSH || op_r == OP_TICK) && !slot_last) begin
            slot_r  <= slot_r + SW'(1);
            state_r <= S_RD;
          end else begin
            state_r <= S_ST;
          end
        end
        S_ST: begin
          out_valid_r  <= 1'b1;
          out_kind_r   <= 1'b0;
          out_status_r <= st_r;
          out_slot_r   <= sid_r;
          out_left_r   <= 7'd0;
          out_right_r  <= 7'd0;
          out_last_r   <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_status      = out_status_r;
  assign out_slot_id     = out_slot_r;
  assign out_left_level  = out_left_r;
  assign out_right_level = out_right_r;
  assign out_last        = out_last_r;

endmodule

>>> sv/res_checker.sv
// Port-level checks for the rumble effect scheduler, bound to the top level.
module res_checker import res_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_kind,
  input logic [2:0] out_status,
  input logic       out_last
);

  // a taken request keeps the block busy until its status is out
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

  // last marks the status item only
  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_kind)
    else $error("last on a packet");

  a_packet_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> !out_last && out_status == ST_OK)
    else $error("bad packet framing");

  // the block goes idle only as its status item comes out
  a_idle_after_status: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid && out_last)
    else $error("idle without final status");

endmodule

bind rumble_effect_scheduler res_checker u_res_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_kind  (out_kind),
  .out_status(out_status),
  .out_last  (out_last)
);

>>> verif/rumble_effect_scheduler_test.sv
// Testbench for the rumble effect scheduler: directed and random requests, self-checking.
`timescale 1ns / 100ps

module rumble_effect_scheduler_test;
  import res_pkg::*;

  localparam int NSLOT = 8;
  localparam int IDLE_LIMIT = 5000;   // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 40;   // margin beyond the longest request, a flush or tick

  typedef struct {
    logic [2:0]  op;
    logic [3:0]  eid;
    logic [15:0] who;
    logic [15:0] strong_mag;
    logic [15:0] weak_mag;
    logic [15:0] dly;
    logic [15:0] len;
    logic [15:0] cnt;
    bit          hold;   // wait for all outstanding results before this one
  } request_t;

  typedef struct {
    logic       kind;
    logic [2:0] status;
    logic [2:0] slot;
    logic [6:0] left;
    logic [6:0] right;
    logic       last;
  } rumble_out_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [2:0] in_opcode = '0;
  logic signed [3:0] in_effect_id = '0;
  logic [15:0] in_requester = '0, in_strong_magnitude = '0, in_weak_magnitude = '0;
  logic [15:0] in_delay_ms = '0, in_length_ms = '0, in_play_count = '0;
  logic out_valid, out_kind, out_last;
  logic [2:0] out_status, out_slot_id;
  logic [6:0] out_left_level, out_right_level;

  rumble_effect_scheduler dut (.*);

  always #1 clk = ~clk;

  // Shadow slot table for prediction.
  logic [2:0]  sh_flags [NSLOT];   // bit F_STARTED, F_PLAYING, F_USED
  logic [15:0] sh_owner [NSLOT];
  logic [6:0]  sh_left [NSLOT], sh_right [NSLOT];
  logic [15:0] sh_delay [NSLOT], sh_length [NSLOT], sh_repeats [NSLOT], sh_cdown [NSLOT];

  request_t    pending_reqs[$];
  rumble_out_t expected_outs[$];
  request_t    cur;
  int errors = 0;
  int idle_cycles = 0;
  int gap_left = 0, burst_left = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Rumble packet with the current playing-set sums, saturated.
  task automatic push_packet(input int s);
    int l, r;
    rumble_out_t p;
    l = 0; r = 0;
    for (int i = 0; i < NSLOT; i++)
      if (sh_flags[i][F_USED] && sh_flags[i][F_PLAYING]) begin
        l += sh_left[i]; r += sh_right[i];
      end
    p.kind = 1; p.status = ST_OK; p.slot = s[2:0];
    p.left = (l > LEVEL_MAX) ? 7'(LEVEL_MAX) : 7'(l);
    p.right = (r > LEVEL_MAX) ? 7'(LEVEL_MAX) : 7'(r);
    p.last = 0;
    expected_outs.push_back(p);
  endtask

  function automatic bit can_touch(input int id, input logic [15:0] who);
    if (id < 0 || id >= NSLOT) return 0;
    if (!sh_flags[id][F_USED]) return 0;
    return who == 0 || sh_owner[id] == who;
  endfunction

  function automatic bit armed(input int id);
    return sh_flags[id][F_STARTED] || sh_flags[id][F_PLAYING];
  endfunction

  task automatic predict_request(input request_t rq);
    int id, i;
    logic [2:0] st, sid;
    rumble_out_t s;
    id = int'($signed(rq.eid));
    st = ST_OK; sid = 3'd0;
    case (rq.op)
      OP_UPLOAD: begin
        sid = rq.eid[2:0];
        if (id == -1) begin
          for (i = 0; i < NSLOT && sh_flags[i][F_USED]; i++) ;
          if (i >= NSLOT) begin
            st = ST_NOSPACE; sid = 3'd0;
          end else begin
            id = i; sid = i[2:0];
            sh_owner[i] = rq.who;
            sh_flags[i] = 3'b100;
          end
        end else if (!can_touch(id, rq.who)) begin
          st = ST_DENIED;
        end
        if (st == ST_OK) begin
          if (armed(id)) begin
            if (rq.dly != sh_delay[id] || rq.len != sh_length[id]) begin
              st = ST_UNSUP;
            end else begin
              sh_left[id] = 7'(rq.weak_mag >> MAG_SHIFT);
              sh_right[id] = 7'(rq.strong_mag >> MAG_SHIFT);
              push_packet(id);
            end
          end else begin
            sh_left[id] = 7'(rq.weak_mag >> MAG_SHIFT);
            sh_right[id] = 7'(rq.strong_mag >> MAG_SHIFT);
            sh_delay[id] = rq.dly;
            sh_length[id] = rq.len;
          end
        end
      end
      OP_PLAY: begin
        sid = rq.eid[2:0];
        if (!can_touch(id, rq.who)) begin
          st = ST_DENIED;
        end else if (rq.cnt != 0) begin
          if (armed(id)) begin
            st = ST_BUSY;
          end else begin
            sh_repeats[id] = rq.cnt;
            if (sh_delay[id] != 0) begin
              sh_flags[id][F_STARTED] = 1;
              sh_cdown[id] = sh_delay[id];
            end else begin
              sh_flags[id][F_PLAYING] = 1;
              push_packet(id);
              sh_cdown[id] = sh_length[id];
            end
          end
        end else if (sh_flags[id][F_STARTED]) begin
          sh_flags[id][F_STARTED] = 0;       // disarm silently
        end else if (sh_flags[id][F_PLAYING]) begin
          sh_flags[id][F_PLAYING] = 0;
          push_packet(id);
        end
      end
      OP_ERASE: begin
        sid = rq.eid[2:0];
        if (!can_touch(id, rq.who)) begin
          st = ST_DENIED;
        end else begin
          sh_flags[id][F_PLAYING] = 0;
          push_packet(id);
          sh_flags[id] = '0;
        end
      end
      OP_FLUSH: begin
        // no privilege for requester 0 here
        for (i = 0; i < NSLOT; i++)
          if (sh_owner[i] == rq.who && sh_flags[i][F_USED]) begin
            sh_flags[i][F_PLAYING] = 0;
            push_packet(i);
            sh_flags[i] = '0;
          end
      end
      OP_TICK: begin
        for (i = 0; i < NSLOT; i++) begin
          if (!armed(i)) continue;
          if (sh_cdown[i] > 1) begin
            sh_cdown[i]--;
            continue;
          end
          if (sh_flags[i][F_STARTED]) begin
            sh_flags[i][F_STARTED] = 0;
            sh_flags[i][F_PLAYING] = 1;
            push_packet(i);
            sh_cdown[i] = sh_length[i];
          end else begin
            sh_flags[i][F_PLAYING] = 0;
            push_packet(i);
            sh_repeats[i] = sh_repeats[i] - 16'd1;   // wraps
            if (sh_repeats[i] != 0) begin
              sh_flags[i][F_STARTED] = 1;
              sh_cdown[i] = sh_delay[i];
            end
          end
        end
      end
      default: st = ST_INVALID;
    endcase
    s.kind = 0; s.status = st; s.slot = sid; s.left = 0; s.right = 0; s.last = 1;
    expected_outs.push_back(s);
  endtask

  function automatic request_t mk(input logic [2:0] op, input logic [3:0] eid,
                                  input logic [15:0] who, input logic [15:0] strong_mag = 0,
                                  input logic [15:0] weak_mag = 0, input logic [15:0] dly = 0,
                                  input logic [15:0] len = 0, input logic [15:0] cnt = 0,
                                  input bit hold = 0);
    request_t r;
    r.op = op; r.eid = eid; r.who = who; r.strong_mag = strong_mag; r.weak_mag = weak_mag;
    r.dly = dly; r.len = len; r.cnt = cnt; r.hold = hold;
    return r;
  endfunction

  function automatic logic [15:0] pick_who();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
  endfunction

  function automatic logic [15:0] pick_time();
    return ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 3)) : 16'($urandom);
  endfunction

  // Mostly well-formed requests on a few owners, with ticks to drive playback.
  function automatic request_t rand_request(input bit hold);
    request_t r;
    int k;
    k = $urandom_range(0, 99);
    r.strong_mag = 16'($urandom); r.weak_mag = 16'($urandom);
    r.who = pick_who(); r.dly = pick_time(); r.len = pick_time();
    r.cnt = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    r.eid = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7));
    r.hold = hold;
    if (k < 35) r.op = OP_TICK;
    else if (k < 60) begin
      r.op = OP_UPLOAD;
      if ($urandom_range(0, 9) < 4) r.eid = 4'hf;
    end
    else if (k < 80) r.op = OP_PLAY;
    else if (k < 88) r.op = OP_ERASE;
    else if (k < 93) r.op = OP_FLUSH;
    else r.op = 3'($urandom);
    return r;
  endfunction

  // Driver: holds start until transfer, then offers the next pending request.
  always @(posedge clk) begin
    bit offer;
    if (!rst_n) begin
      start <= 0;
    end else begin
      if (start && !busy) begin
        predict_request(cur);
        idle_cycles = 0;
      end
      if (!(start && busy)) begin
        offer = 0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].hold && expected_outs.size() > 0)) begin
          offer = 1;
          cur = pending_reqs.pop_front();
          in_opcode <= cur.op;
          in_effect_id <= cur.eid;
          in_requester <= cur.who;
          in_strong_magnitude <= cur.strong_mag;
          in_weak_magnitude <= cur.weak_mag;
          in_delay_ms <= cur.dly;
          in_length_ms <= cur.len;
          in_play_count <= cur.cnt;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        start <= offer;
      end
    end
  end

  // Monitor: every strobed result against the oldest expectation; watchdog.
  always @(posedge clk) begin
    rumble_out_t e;
    if (rst_n) begin
      idle_cycles++;
      if (out_valid) begin
        idle_cycles = 0;
        if (expected_outs.size() == 0) begin
          report($sformatf("unexpected result kind=%0d status=%0d slot=%0d",
                           out_kind, out_status, out_slot_id));
        end else begin
          e = expected_outs.pop_front();
          if (out_kind !== e.kind)
            report($sformatf("kind %0d, want %0d", out_kind, e.kind));
          if (out_status !== e.status)
            report($sformatf("status %0d, want %0d", out_status, e.status));
          if (out_slot_id !== e.slot)
            report($sformatf("slot_id %0d, want %0d", out_slot_id, e.slot));
          if (out_left_level !== e.left)
            report($sformatf("left_level %0d, want %0d", out_left_level, e.left));
          if (out_right_level !== e.right)
            report($sformatf("right_level %0d, want %0d", out_right_level, e.right));
          if (out_last !== e.last)
            report($sformatf("last %0d, want %0d", out_last, e.last));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      sh_flags[i] = '0; sh_owner[i] = '0; sh_left[i] = '0; sh_right[i] = '0;
      sh_delay[i] = '0; sh_length[i] = '0; sh_repeats[i] = '0; sh_cdown[i] = '0;
    end
    // Directed: allocation, armed upload, busy, privilege, bad ids, invalid ops, ticks, a full table, flushes.
    pending_reqs.push_back(mk(OP_UPLOAD, 4'hf, 16'd5, 16'hffff, 16'hffff, 0, 2));
    pending_reqs.push_back(mk(OP_UPLOAD, 4'hf, 16'd6, 16'h0000, 16'h8000, 2, 1));
    pending_reqs.push_back(mk(OP_PLAY, 4'd0, 16'd5, 0, 0, 0, 0, 16'd2));
    pending_reqs.push_back(mk(OP_PLAY, 4'd0, 16'd5, 0, 0, 0, 0, 16'd1));
    pending_reqs.push_back(mk(OP_UPLOAD, 4'd0, 16'd5, 16'h1234, 16'h4321, 1, 2));
    pending_reqs.push_back(mk(OP_UPLOAD, 4'd0, 16'd5, 16'h7e00, 16'h0200, 0, 2));
    pending_reqs.push_back(mk(OP_PLAY, 4'd1, 16'd7, 0, 0, 0, 0, 16'd1));
    pending_reqs.push_back(mk(OP_PLAY, 4'd1, 16'd0, 0, 0, 0, 0, 16'hffff));
    repeat (4) pending_reqs.push_back(mk(OP_TICK, 4'd0, 16'd0));
    pending_reqs.push_back(mk(OP_PLAY, 4'd1, 16'd6, 0, 0, 0, 0, 16'd0));
    pending_reqs.push_back(mk(OP_UPLOAD, 4'd7, 16'd0));
    pending_reqs.push_back(mk(OP_UPLOAD, 4'h8, 16'd0));
    pending_reqs.push_back(mk(OP_PLAY, 4'he, 16'd0, 0, 0, 0, 0, 16'd1));
    pending_reqs.push_back(mk(OP_ERASE, 4'd0, 16'd0));
    pending_reqs.push_back(mk(OP_ERASE, 4'd5, 16'd0));
    pending_reqs.push_back(mk(3'd5, 4'd3, 16'd1));
    pending_reqs.push_back(mk(3'd6, 4'd0, 16'd1));
    pending_reqs.push_back(mk(3'd7, 4'd7, 16'hffff, 0, 0, 0, 0, 0, 1));
    repeat (8) pending_reqs.push_back(mk(OP_UPLOAD, 4'hf, 16'hffff, 16'hffff, 16'hffff,
                                         16'hffff, 16'hffff));
    pending_reqs.push_back(mk(OP_FLUSH, 4'd0, 16'd0));
    pending_reqs.push_back(mk(OP_FLUSH, 4'd0, 16'hffff));
    for (int n = 0; n < 90; n++)
      pending_reqs.push_back(rand_request(n % 40 == 39));

    repeat (9) @(posedge clk);
    rst_n <= 1;
    wait (pending_reqs.size() == 0 && !start && expected_outs.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_outs.size() != 0)
      report($sformatf("%0d results never arrived", expected_outs.size()));
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
